/* src/vgc_pkg.sv */
// ----------------------------------------------------------------------------
// vgc_pkg
// shared constants and types for the voxel grid centroid downsampler
// ----------------------------------------------------------------------------
`default_nettype none
package vgc_pkg;
    localparam int COORD_W     = 24;
    localparam int SUM_W       = 40;
    localparam int CNT_W       = 17;
    localparam int VSIZE_W     = 16;
    localparam int MAX_VOXELS  = 1024;
    localparam int IDX_W       = $clog2(MAX_VOXELS);
    localparam int USED_W      = IDX_W + 1;
    localparam int MAX_POINTS  = 65536;
    localparam int DIVD_W      = SUM_W + 1;
    localparam int DIVS_W      = CNT_W;
    localparam int STEP_W      = $clog2(DIVD_W);

    localparam logic [VSIZE_W-1:0] VSIZE_RESET = VSIZE_W'(128);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_EMPTY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] key_x;
        logic signed [COORD_W-1:0] key_y;
        logic signed [COORD_W-1:0] key_z;
        logic signed [SUM_W-1:0]   sum_x;
        logic signed [SUM_W-1:0]   sum_y;
        logic signed [SUM_W-1:0]   sum_z;
        logic [CNT_W-1:0]          count;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic              rem_nz;
    } div_rsp_t;
endpackage
`default_nettype wire

/* src/vgc_in_if.sv */
// ----------------------------------------------------------------------------
// vgc_in_if
// input channel: operation and point coordinates
// ----------------------------------------------------------------------------
`default_nettype none
interface vgc_in_if;
    import vgc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;

    modport source (output valid, operation, point_x, point_y, point_z, input ready);
    modport sink   (input valid, operation, point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

/* src/vgc_out_if.sv */
// ----------------------------------------------------------------------------
// vgc_out_if
// output channel: centroid or bypassed point with flags
// ----------------------------------------------------------------------------
`default_nettype none
interface vgc_out_if;
    import vgc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      last_centroid;
    logic                      status;
    logic                      overflow_seen;

    modport source (output valid, out_x, out_y, out_z, last_centroid, status,
                    overflow_seen, input ready);
    modport sink   (input valid, out_x, out_y, out_z, last_centroid, status,
                    overflow_seen, output ready);
endinterface
`default_nettype wire

/* src/vgc_div.sv */
// ----------------------------------------------------------------------------
// vgc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module vgc_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire vgc_pkg::div_req_t req,
    output vgc_pkg::div_rsp_t      rsp
);
    import vgc_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVD_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            rem_next = fits ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem_nz   = rem_reg != '0;
endmodule
`default_nettype wire

/* src/voxel_grid_centroid_downsample_unit.sv */
// ----------------------------------------------------------------------------
// voxel_grid_centroid_downsample_unit
// voxel grid filter: accumulates points per voxel, reads back centroids
// ----------------------------------------------------------------------------
// add point: 3 divides, one per coordinate, then a scan of the stored voxels,
//   a read (ST_SCAN_RD) and a key compare (ST_SCAN_CMP) per entry, ending on
//   a match at entry k or on allocating a new voxel among n stored ones
// read request: entry fetch (ST_RD_ISSUE, ST_RD_CAP), 3 divides, then emit
// bypass and empty read go straight to emit; one item in flight at a time
// reset clears counters, overflow flag, output valid; table contents are kept
`default_nettype none
module voxel_grid_centroid_downsample_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [vgc_pkg::VSIZE_W-1:0] cfg_wdata,
    vgc_in_if.sink                          in_ch,
    vgc_out_if.source                       out_ch
);
    import vgc_pkg::*;

    // one-hot sequencer states
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DIV_GO   = 8'b0000_0010,
        ST_DIV_WAIT = 8'b0000_0100,
        ST_SCAN_RD  = 8'b0000_1000,
        ST_SCAN_CMP = 8'b0001_0000,
        ST_RD_ISSUE = 8'b0010_0000,
        ST_RD_CAP   = 8'b0100_0000,
        ST_EMIT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [VSIZE_W-1:0] vsize_reg;

    // control state
    logic [USED_W-1:0] used_reg, used_next;
    logic [USED_W-1:0] rp_reg, rp_next;
    logic [USED_W-1:0] scan_reg, scan_next;
    logic              ovf_reg, ovf_next;
    logic [1:0]        coord_reg, coord_next;
    logic              mode_reg, mode_next;

    // payload holding
    logic signed [COORD_W-1:0] pt_reg [3];
    logic signed [COORD_W-1:0] res_reg [3];
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic [CNT_W-1:0]          cnt_reg;
    logic                      last_reg, last_next;
    logic                      stat_reg, stat_next;

    // output register
    logic                      ovalid_reg, ovalid_next;
    logic signed [COORD_W-1:0] ox_reg, oy_reg, oz_reg;
    logic                      olast_reg, ostat_reg, oovf_reg;

    // table memory, one read and one write port
    entry_t            mem [MAX_VOXELS];
    entry_t            mem_q;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic              wr_en;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // per-coordinate operand selection
    logic signed [COORD_W-1:0] sel_pt;
    logic signed [SUM_W-1:0]   sel_sum;
    logic                      sel_neg;
    logic [COORD_W-1:0]        pt_mag;
    logic [SUM_W-1:0]          sum_mag;
    logic [COORD_W-1:0]        q_lo;
    logic signed [COORD_W-1:0] div_res;

    logic in_xfer;
    logic emit_load;
    logic key_hit;

    vgc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = state_reg == ST_IDLE;
    assign emit_load   = (state_reg == ST_EMIT) && (!ovalid_reg || out_ch.ready);

    assign sel_pt  = pt_reg[coord_reg];
    assign sel_sum = sum_reg[coord_reg];
    assign sel_neg = (mode_reg == OP_ADD) ? sel_pt[COORD_W-1] : sel_sum[SUM_W-1];
    assign pt_mag  = sel_pt[COORD_W-1] ? COORD_W'(-sel_pt) : COORD_W'(sel_pt);
    assign sum_mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);

    // floor mode divides by voxel size, round mode adds half the count first
    always_comb
    begin
        div_req.start = state_reg == ST_DIV_GO;
        if (mode_reg == OP_ADD)
        begin
            div_req.dividend = DIVD_W'(pt_mag);
            div_req.divisor  = DIVS_W'(vsize_reg);
        end
        else
        begin
            div_req.dividend = DIVD_W'(sum_mag) + DIVD_W'(cnt_reg >> 1);
            div_req.divisor  = cnt_reg;
        end
    end

    // sign fix-up: floor rounds negatives down, centroid rounds half away
    assign q_lo = div_rsp.quotient[COORD_W-1:0];
    always_comb
    begin
        if (!sel_neg)
            div_res = q_lo;
        else if ((mode_reg == OP_ADD) && div_rsp.rem_nz)
            div_res = ~q_lo;
        else
            div_res = -q_lo;
    end

    assign key_hit = (mem_q.key_x == res_reg[0]) && (mem_q.key_y == res_reg[1]) &&
                     (mem_q.key_z == res_reg[2]);

    always_comb
    begin
        rd_addr = (state_reg == ST_RD_ISSUE) ? rp_reg[IDX_W-1:0] : scan_reg[IDX_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        rp_next     = rp_reg;
        scan_next   = scan_reg;
        ovf_next    = ovf_reg;
        coord_next  = coord_reg;
        mode_next   = mode_reg;
        last_next   = last_reg;
        stat_next   = stat_reg;
        wr_en       = 1'b0;
        wr_addr     = scan_reg[IDX_W-1:0];
        wr_data     = mem_q;
        ovalid_next = ovalid_reg && !out_ch.ready;
        if (emit_load)
            ovalid_next = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mode_next  = in_ch.operation;
                    coord_next = '0;
                    last_next  = 1'b0;
                    stat_next  = STAT_OK;
                    if (in_ch.operation == OP_READ)
                    begin
                        if (rp_reg >= used_reg)
                        begin
                            // empty table transfer
                            stat_next  = STAT_EMPTY;
                            used_next  = '0;
                            rp_next    = '0;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            last_next  = (rp_reg + 1'b1) == used_reg;
                            state_next = ST_RD_ISSUE;
                        end
                    end
                    else if (vsize_reg == '0)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (coord_reg == 2'd2)
                    begin
                        scan_next  = '0;
                        state_next = (mode_reg == OP_ADD) ? ST_SCAN_RD : ST_EMIT;
                    end
                    else
                    begin
                        coord_next = coord_reg + 1'b1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (scan_reg == used_reg)
                begin
                    // no match: allocate a new voxel or flag overflow
                    state_next = ST_IDLE;
                    if (used_reg == USED_W'(MAX_VOXELS))
                        ovf_next = 1'b1;
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_data.key_x = res_reg[0];
                        wr_data.key_y = res_reg[1];
                        wr_data.key_z = res_reg[2];
                        wr_data.sum_x = SUM_W'(pt_reg[0]);
                        wr_data.sum_y = SUM_W'(pt_reg[1]);
                        wr_data.sum_z = SUM_W'(pt_reg[2]);
                        wr_data.count = CNT_W'(1);
                        used_next     = used_reg + 1'b1;
                    end
                end
                else
                    state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (key_hit)
                begin
                    state_next = ST_IDLE;
                    if (mem_q.count >= CNT_W'(MAX_POINTS))
                        ovf_next = 1'b1;
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_data.sum_x = mem_q.sum_x + SUM_W'(pt_reg[0]);
                        wr_data.sum_y = mem_q.sum_y + SUM_W'(pt_reg[1]);
                        wr_data.sum_z = mem_q.sum_z + SUM_W'(pt_reg[2]);
                        wr_data.count = mem_q.count + 1'b1;
                    end
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_RD_ISSUE:
                state_next = ST_RD_CAP;
            ST_RD_CAP:
                state_next = ST_DIV_GO;
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                    if ((mode_reg == OP_READ) && (stat_reg == STAT_OK))
                    begin
                        if (last_reg)
                        begin
                            used_next = '0;
                            rp_next   = '0;
                        end
                        else
                            rp_next = rp_reg + 1'b1;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vsize_reg  <= VSIZE_RESET;
            used_reg   <= '0;
            rp_reg     <= '0;
            scan_reg   <= '0;
            ovf_reg    <= 1'b0;
            coord_reg  <= '0;
            mode_reg   <= OP_ADD;
            last_reg   <= 1'b0;
            stat_reg   <= STAT_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            rp_reg     <= rp_next;
            scan_reg   <= scan_next;
            ovf_reg    <= ovf_next;
            coord_reg  <= coord_next;
            mode_reg   <= mode_next;
            last_reg   <= last_next;
            stat_reg   <= stat_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
                vsize_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pt_reg[0] <= in_ch.point_x;
            pt_reg[1] <= in_ch.point_y;
            pt_reg[2] <= in_ch.point_z;
            if ((in_ch.operation == OP_READ) || (vsize_reg != '0))
            begin
                res_reg[0] <= '0;
                res_reg[1] <= '0;
                res_reg[2] <= '0;
            end
            else
            begin
                res_reg[0] <= in_ch.point_x;
                res_reg[1] <= in_ch.point_y;
                res_reg[2] <= in_ch.point_z;
            end
        end
        else if ((state_reg == ST_DIV_WAIT) && div_rsp.done)
            res_reg[coord_reg] <= div_res;
        if (state_reg == ST_RD_CAP)
        begin
            sum_reg[0] <= mem_q.sum_x;
            sum_reg[1] <= mem_q.sum_y;
            sum_reg[2] <= mem_q.sum_z;
            cnt_reg    <= mem_q.count;
        end
        if (emit_load)
        begin
            ox_reg    <= res_reg[0];
            oy_reg    <= res_reg[1];
            oz_reg    <= res_reg[2];
            olast_reg <= last_reg;
            ostat_reg <= stat_reg;
            oovf_reg  <= ovf_reg;
        end
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        mem_q <= mem[rd_addr];
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.out_x         = ox_reg;
    assign out_ch.out_y         = oy_reg;
    assign out_ch.out_z         = oz_reg;
    assign out_ch.last_centroid = olast_reg;
    assign out_ch.status        = ostat_reg;
    assign out_ch.overflow_seen = oovf_reg;

    // fill count never exceeds the table
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(MAX_VOXELS))
        else $error("fill count beyond table depth");

    // read-out pointer stays within the filled entries
    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= used_reg)
        else $error("read pointer past fill count");

    // overflow flag is sticky
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    // table writes only target filled or next free entry
    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, wr_addr} <= used_reg))
        else $error("table write outside filled range");
endmodule
`default_nettype wire

/* verif/voxel_grid_centroid_downsample_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_centroid_downsample_unit_tb
// self-checking bench for the voxel grid centroid downsampler
// ----------------------------------------------------------------------------
// a directed table covers empty reads, bypass, coordinate extremes, rounding
// ties and adds during read-out; random phases then sweep voxel sizes with
// clustered and full-range points, the last phase with no idling. Every
// transfer on the output channel is checked against an in-bench predictor
// of the voxel table.
// ----------------------------------------------------------------------------
module voxel_grid_centroid_downsample_unit_tb;
    import vgc_pkg::*;

    // adds produce no transfer, so idle time must cover a worst-case scan
    localparam int SETTLE_CYCLES = 2600;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
        logic                      status;
        logic                      ovf;
    } centroid_t;

    typedef struct {
        int   set_vs;      // >= 0: register write instead of a transfer
        logic op;
        int   x;
        int   y;
        int   z;
        bit   typed;       // expected result given in the row
        int   ex;
        int   ey;
        int   ez;
        logic el;
        logic es;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [VSIZE_W-1:0] cfg_wdata;

    vgc_in_if  in_ch ();
    vgc_out_if out_ch ();

    voxel_grid_centroid_downsample_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state: the voxel table as the block should hold it
    int        pred_vsize;
    int        vox_key_x [MAX_VOXELS];
    int        vox_key_y [MAX_VOXELS];
    int        vox_key_z [MAX_VOXELS];
    longint    vox_sum_x [MAX_VOXELS];
    longint    vox_sum_y [MAX_VOXELS];
    longint    vox_sum_z [MAX_VOXELS];
    int        vox_count [MAX_VOXELS];
    int        vox_used;
    int        vox_rd_ptr;
    bit        vox_ovf;

    centroid_t pending_centroids[$];
    int        fail_count;
    bit        idle_on;
    int        in_gap;
    int        out_stall;

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int floor_quot(longint p, longint d);
        longint q;
        q = p / d;
        if ((p % d) != 0 && p < 0)
            q = q - 1;
        return int'(q);
    endfunction

    // nearest, ties away from zero
    function automatic longint round_quot(longint s, longint c);
        if (s >= 0)
            return (s + c / 2) / c;
        return -((-s + c / 2) / c);
    endfunction

    // updates the voxel table for one accepted item; returns 1 if it yields a transfer
    function automatic bit voxel_update(logic op, logic signed [COORD_W-1:0] px,
                                        logic signed [COORD_W-1:0] py,
                                        logic signed [COORD_W-1:0] pz,
                                        output centroid_t res);
        int i;
        int hit;
        int kx;
        int ky;
        int kz;
        int c;
        res = '{x: '0, y: '0, z: '0, last: 1'b0, status: STAT_OK, ovf: 1'b0};
        if (op == OP_READ)
        begin
            res.ovf = vox_ovf;
            if (vox_rd_ptr >= vox_used)
            begin
                vox_used = 0;
                vox_rd_ptr = 0;
                res.status = STAT_EMPTY;
                return 1'b1;
            end
            i = vox_rd_ptr;
            c = (vox_count[i] == 0) ? 1 : vox_count[i];
            res.x = COORD_W'(round_quot(vox_sum_x[i], c));
            res.y = COORD_W'(round_quot(vox_sum_y[i], c));
            res.z = COORD_W'(round_quot(vox_sum_z[i], c));
            res.last = (i + 1 == vox_used);
            if (res.last)
            begin
                vox_used = 0;
                vox_rd_ptr = 0;
            end
            else
                vox_rd_ptr = i + 1;
            return 1'b1;
        end
        if (pred_vsize == 0)
        begin
            res.x = px;
            res.y = py;
            res.z = pz;
            res.ovf = vox_ovf;
            return 1'b1;
        end
        kx = floor_quot(px, pred_vsize);
        ky = floor_quot(py, pred_vsize);
        kz = floor_quot(pz, pred_vsize);
        hit = vox_used;
        for (i = 0; i < vox_used; i++)
        begin
            if (vox_key_x[i] == kx && vox_key_y[i] == ky && vox_key_z[i] == kz)
            begin
                hit = i;
                break;
            end
        end
        if (hit >= vox_used)
        begin
            if (vox_used >= MAX_VOXELS)
            begin
                vox_ovf = 1'b1;
                return 1'b0;
            end
            hit = vox_used;
            vox_key_x[hit] = kx;
            vox_key_y[hit] = ky;
            vox_key_z[hit] = kz;
            vox_sum_x[hit] = 0;
            vox_sum_y[hit] = 0;
            vox_sum_z[hit] = 0;
            vox_count[hit] = 0;
            vox_used = hit + 1;
        end
        if (vox_count[hit] >= MAX_POINTS)
        begin
            vox_ovf = 1'b1;
            return 1'b0;
        end
        vox_sum_x[hit] += px;
        vox_sum_y[hit] += py;
        vox_sum_z[hit] += pz;
        vox_count[hit] += 1;
        return 1'b0;
    endfunction

    // one transfer on the input channel; valid stays high into the next item
    task automatic send_item(logic op, logic signed [COORD_W-1:0] px,
                             logic signed [COORD_W-1:0] py,
                             logic signed [COORD_W-1:0] pz,
                             bit typed, centroid_t typed_res);
        centroid_t res;
        int n;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 10);
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.point_x   <= px;
        in_ch.point_y   <= py;
        in_ch.point_z   <= pz;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (voxel_update(op, px, py, pz, res))
        begin
            if (typed)
                res = typed_res;
            pending_centroids.insert(pending_centroids.size(), res);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_centroids.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vsize(int v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= VSIZE_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred_vsize = v;
    endtask

    // read until the set is fully drained
    task automatic read_out_all();
        centroid_t none;
        none = '{x: '0, y: '0, z: '0, last: 1'b0, status: STAT_OK, ovf: 1'b0};
        while (vox_used != 0)
            send_item(OP_READ, '0, '0, '0, 1'b0, none);
    endtask

    // random output backpressure in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_stall    <= 0;
        end
        else if (out_stall > 0)
        begin
            out_ch.ready <= 1'b0;
            out_stall    <= out_stall - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_ch.ready <= 1'b0;
            out_stall    <= $urandom_range(0, 9);
        end
        else
            out_ch.ready <= 1'b1;
    end

    // check each output transfer against the oldest pending centroid
    always @(posedge clk)
    begin
        centroid_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_centroids.size() == 0)
            begin
                $display("%0t: unexpected transfer x=%0d y=%0d z=%0d", $time,
                         out_ch.out_x, out_ch.out_y, out_ch.out_z);
                fail_count++;
            end
            else
            begin
                e = pending_centroids.pop_front();
                if (out_ch.out_x !== e.x || out_ch.out_y !== e.y || out_ch.out_z !== e.z ||
                    out_ch.last_centroid !== e.last || out_ch.status !== e.status ||
                    out_ch.overflow_seen !== e.ovf)
                begin
                    $display("%0t: mismatch expected x=%0d y=%0d z=%0d last=%0b st=%0b ovf=%0b",
                             $time, e.x, e.y, e.z, e.last, e.status, e.ovf);
                    $display("%0t:          actual   x=%0d y=%0d z=%0d last=%0b st=%0b ovf=%0b",
                             $time, out_ch.out_x, out_ch.out_y, out_ch.out_z,
                             out_ch.last_centroid, out_ch.status, out_ch.overflow_seen);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        dir_row_t  dir_tab[22];
        centroid_t tr;
        int        vs_list[6];
        int        p;
        int        k;
        int        span;
        int        n_items;
        logic      op;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;

        // set_vs, op, x, y, z, typed, ex, ey, ez, last, status
        dir_tab = '{
            // empty read straight after reset
            '{-1, OP_READ, 0, 0, 0, 1, 0, 0, 0, 1'b0, STAT_EMPTY},
            '{-1, OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, 127, 127, 127, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, -1, -1, -1, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, 8388607, -8388608, 1, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, 1, 2, -1, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, -8388608, 8388607, -256, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, STAT_OK},
            // add during read-out: one hit on a read voxel, one new voxel
            '{-1, OP_ADD, 3, 3, 3, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, 1000, 1000, 1000, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0, STAT_EMPTY},
            // bypass: points come straight back
            '{0, OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, 8388607, -8388608, 0, 1, 8388607, -8388608, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, -8388608, 8388607, -1, 1, -8388608, 8388607, -1, 1'b0, STAT_OK},
            '{-1, OP_READ, 0, 0, 0, 1, 0, 0, 0, 1'b0, STAT_EMPTY},
            // largest voxel, rounding ties on both signs
            '{65535, OP_ADD, 1, 0, -1, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, 2, 0, -2, 0, 0, 0, 0, 1'b0, STAT_OK},
            '{-1, OP_ADD, -1, 1, 0, 0, 0, 0, 0, 1'b0, STAT_OK}
        };
        vs_list = '{128, 1, 65535, 256, 0, 37};

        fail_count = 0;
        idle_on    = 1'b1;
        pred_vsize = VSIZE_RESET;
        vox_used   = 0;
        vox_rd_ptr = 0;
        vox_ovf    = 1'b0;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_ADD;
        in_ch.point_x   = '0;
        in_ch.point_y   = '0;
        in_ch.point_z   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < 22; r++)
        begin
            if (dir_tab[r].set_vs >= 0)
                write_vsize(dir_tab[r].set_vs);
            else
            begin
                tr = '{x: COORD_W'(dir_tab[r].ex), y: COORD_W'(dir_tab[r].ey),
                       z: COORD_W'(dir_tab[r].ez), last: dir_tab[r].el,
                       status: dir_tab[r].es, ovf: 1'b0};
                send_item(dir_tab[r].op, COORD_W'(dir_tab[r].x), COORD_W'(dir_tab[r].y),
                          COORD_W'(dir_tab[r].z), dir_tab[r].typed, tr);
            end
        end
        read_out_all();

        // random phases across voxel sizes, each ending with a full read-out
        for (p = 0; p < 6; p++)
        begin
            // last phase runs with no idling on either side
            if (p == 5)
                idle_on = 1'b0;
            write_vsize((p == 5) ? $urandom_range(2, 65534) : vs_list[p]);
            span = (pred_vsize == 0) ? 64 : 4 * pred_vsize;
            n_items = 60;
            for (k = 0; k < n_items; k++)
            begin
                op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ADD;
                if ($urandom_range(0, 4) == 0)
                begin
                    // full range, reaches every bit
                    px = COORD_W'($urandom);
                    py = COORD_W'($urandom);
                    pz = COORD_W'($urandom);
                end
                else
                begin
                    // clustered so voxels get reused
                    px = COORD_W'($urandom_range(0, 2 * span) - span);
                    py = COORD_W'($urandom_range(0, 2 * span) - span);
                    pz = COORD_W'($urandom_range(0, 2 * span) - span);
                end
                send_item(op, px, py, pz, 1'b0, tr);
            end
            read_out_all();
        end
        send_item(OP_READ, '0, '0, '0, 1'b0, tr);

        wait_drained();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* sim.f */
src/vgc_pkg.sv
src/vgc_in_if.sv
src/vgc_out_if.sv
src/vgc_div.sv
src/voxel_grid_centroid_downsample_unit.sv
verif/voxel_grid_centroid_downsample_unit_tb.sv
